@@ hdl/slid_pkg.sv @@
// slid_pkg: shared types and constants for the sorted list core
// request and response structs, request and status codes, list sizing
// no dependencies
package slid_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic [5:0]         read_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         position;
        logic [6:0]         count;
        logic signed [31:0] read_value;
    } t_rsp;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic               cmp;
        logic               ins;
        logic               del;
        logic [1:0]         req_type;
        logic signed [31:0] key;
        logic [5:0]         read_index;
        logic [CNT_W-1:0]   count;
    } t_cell_ctl;

    // per cell contribution to the result
    typedef struct packed {
        logic               found;
        logic [CMP_W-1:0]   pos;
        logic signed [31:0] value;
    } t_cell_hit;

endpackage

@@ hdl/slid_cell.sv @@
// slid_cell: one list slot, holding an entry and its compare flags
// shifts toward either neighbor on insert or delete
// depends on slid_pkg
module slid_cell (
    input  logic                         i_clk,
    input  logic [slid_pkg::CMP_W-1:0]   i_index,
    input  slid_pkg::t_cell_ctl          i_ctl,
    input  logic signed [31:0]           i_prev_entry,
    input  logic                         i_prev_t,
    input  logic signed [31:0]           i_next_entry,
    output logic signed [31:0]           o_entry,
    output logic                         o_t,
    output slid_pkg::t_cell_hit          o_hit
);

    logic signed [31:0] r_entry;
    logic               r_t;
    logic               r_eq;
    logic               r_sel;
    logic               w_valid;
    logic               w_b;

    assign w_valid = i_index < slid_pkg::CMP_W'(i_ctl.count);
    assign w_b     = r_t && !i_prev_t;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            if (i_ctl.req_type == slid_pkg::REQ_DELETE) begin
                r_t <= !w_valid || (i_ctl.key >= r_entry);
            end else begin
                r_t <= !w_valid || (i_ctl.key > r_entry);
            end
            r_eq  <= w_valid && (i_ctl.key == r_entry);
            r_sel <= i_index == slid_pkg::CMP_W'(i_ctl.read_index);
        end
        if (i_ctl.ins) begin
            if (w_b) begin
                r_entry <= i_ctl.key;
            end else if (r_t) begin
                r_entry <= i_prev_entry;
            end
        end else if (i_ctl.del) begin
            if (r_t) begin
                r_entry <= i_next_entry;
            end
        end
    end

    assign o_entry     = r_entry;
    assign o_t         = r_t;
    assign o_hit.found = w_b && r_eq;
    assign o_hit.pos   = w_b ? i_index : '0;
    assign o_hit.value = r_sel ? r_entry : 32'sd0;

endmodule

@@ hdl/sorted_list_insert_delete_core.sv @@
// sorted_list_insert_delete_core: descending sorted list of signed keys
// sequencer, result register and the chain of slid_cell slots
// depends on slid_pkg, slid_cell
//
// usage
//   request channel: i_req_valid / o_req_ready carry req_type, key, read_index
//   response channel: o_rsp_valid / i_rsp_ready carry status, position, count,
//   read_value, exactly one response per request, in order
// timing
//   every request passes in turn through accept, compare in all slots at once,
//   then shift the chain on a successful insert or delete and load the response
//   register; a new request is accepted only once the previous one has loaded
//   its response
// stall
//   a new request is accepted while the previous response waits; the shift
//   cycle holds until the response register is free
// reset
//   clears the entry count and the response valid; slot contents are
//   undefined and never read before being written
module sorted_list_insert_delete_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  slid_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output slid_pkg::t_rsp    o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state                        r_state;
    slid_pkg::t_req                r_req;
    logic [slid_pkg::CNT_W-1:0]    r_count;
    logic                          r_rsp_valid;
    slid_pkg::t_rsp                r_rsp;

    slid_pkg::t_cell_ctl           w_ctl;
    slid_pkg::t_rsp                n_rsp;
    logic [slid_pkg::CNT_W-1:0]    n_count;
    logic                          w_rsp_free;
    logic                          w_full;
    logic                          w_found;
    logic                          w_do_ins;
    logic                          w_do_del;
    logic [slid_pkg::CMP_W-1:0]    w_pos;
    logic signed [31:0]            w_val;

    logic signed [31:0]            w_entry [slid_pkg::CAPACITY];
    logic                          w_t     [slid_pkg::CAPACITY];
    slid_pkg::t_cell_hit           w_hit   [slid_pkg::CAPACITY];

    assign w_rsp_free = !r_rsp_valid || i_rsp_ready;
    assign w_full     = r_count == slid_pkg::CNT_W'(slid_pkg::CAPACITY);
    assign w_do_ins   = (r_state == S_APPLY) && w_rsp_free
                        && (r_req.req_type == slid_pkg::REQ_INSERT) && !w_full;
    assign w_do_del   = (r_state == S_APPLY) && w_rsp_free
                        && (r_req.req_type == slid_pkg::REQ_DELETE) && w_found;

    assign w_ctl.cmp        = r_state == S_CMP;
    assign w_ctl.ins        = w_do_ins;
    assign w_ctl.del        = w_do_del;
    assign w_ctl.req_type   = r_req.req_type;
    assign w_ctl.key        = r_req.key;
    assign w_ctl.read_index = r_req.read_index;
    assign w_ctl.count      = r_count;

    for (genvar g = 0; g < slid_pkg::CAPACITY; g++) begin : g_cell
        slid_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (slid_pkg::CMP_W'(g)),
            .i_ctl        (w_ctl),
            .i_prev_entry ((g == 0) ? r_req.key : w_entry[(g == 0) ? 0 : g - 1]),
            .i_prev_t     ((g == 0) ? 1'b0 : w_t[(g == 0) ? 0 : g - 1]),
            .i_next_entry ((g == slid_pkg::CAPACITY - 1) ? w_entry[g]
                           : w_entry[(g == slid_pkg::CAPACITY - 1) ? g : g + 1]),
            .o_entry      (w_entry[g]),
            .o_t          (w_t[g]),
            .o_hit        (w_hit[g])
        );
    end

    // one-hot boundary, so plain or-reduction
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        w_val   = 32'sd0;
        for (int i = 0; i < slid_pkg::CAPACITY; i++) begin
            w_found = w_found | w_hit[i].found;
            w_pos   = w_pos | w_hit[i].pos;
            w_val   = w_val | w_hit[i].value;
        end
    end

    always_comb begin
        n_rsp            = '0;
        n_rsp.status     = slid_pkg::ST_OK;
        n_count          = r_count;
        case (r_req.req_type)
            slid_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_rsp.status = slid_pkg::ST_FULL;
                end else begin
                    n_rsp.position = 7'(w_pos);
                    n_count        = r_count + 1'b1;
                end
            end
            slid_pkg::REQ_DELETE: begin
                if (w_found) begin
                    n_rsp.position = 7'(w_pos);
                    n_count        = r_count - 1'b1;
                end else begin
                    n_rsp.status = slid_pkg::ST_MISS;
                end
            end
            slid_pkg::REQ_READ: begin
                n_rsp.position = 7'(r_req.read_index);
                if (slid_pkg::CMP_W'(r_req.read_index) < slid_pkg::CMP_W'(r_count)) begin
                    n_rsp.read_value = w_val;
                end else begin
                    n_rsp.status = slid_pkg::ST_RANGE;
                end
            end
            default: begin
                n_rsp.status = slid_pkg::ST_OK;
            end
        endcase
        n_rsp.count = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_rsp_free) begin
                        r_rsp       <= n_rsp;
                        r_rsp_valid <= 1'b1;
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ hdl/slid_checker.sv @@
// slid_checker: port level checks for sorted_list_insert_delete_core
// bound to the top level below
// depends on slid_pkg
module slid_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              o_req_ready,
    input  slid_pkg::t_req    i_req,
    input  logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  slid_pkg::t_rsp    o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped while stalled");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.count <= 7'(slid_pkg::CAPACITY))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == slid_pkg::ST_FULL
            |-> o_rsp.count == 7'(slid_pkg::CAPACITY) && o_rsp.position == 7'd0)
        else $error("full status with list not full");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != slid_pkg::ST_OK |-> o_rsp.read_value == 32'sd0)
        else $error("read value on failed request");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted back to back");

endmodule

bind sorted_list_insert_delete_core slid_checker u_slid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
